### hdl/scm_pkg.sv
// Shared types, constants and helpers for the stick-to-command mixer.
`default_nettype none

package scm_pkg;

   // Working width for signed intermediate results (two's complement).
   localparam int ACC_W = 12;

   // Shared multiplier operand and product widths.
   localparam int MUL_A_W = 17;
   localparam int MUL_B_W = 16;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Reciprocals for division by a constant: q = (x * RECIP) >> SHIFT.
   // Exact over the operand ranges used here.
   localparam logic [MUL_A_W-1:0] RECIP_5   = 17'd205;
   localparam int                 SHIFT_5   = 10;
   localparam logic [MUL_A_W-1:0] RECIP_12  = 17'd5462;
   localparam int                 SHIFT_12  = 16;
   localparam logic [MUL_A_W-1:0] RECIP_100 = 17'd83887;
   localparam int                 SHIFT_100 = 23;

   // Register reset values.
   localparam logic [7:0] RST_RAMP_TARGET  = 8'd230;
   localparam logic [7:0] RST_CRUISE_BASE  = 8'd215;
   localparam logic [7:0] RST_BOOST_OFFSET = 8'd39;
   localparam logic [7:0] RST_YAW_CAP      = 8'd168;

   // Stick and command constants.
   localparam logic [7:0]       STICK_MID       = 8'd127;
   localparam logic [7:0]       DEAD_LOW        = 8'd108;
   localparam logic [7:0]       DEAD_HIGH       = 8'd148;
   localparam logic [7:0]       YAW_CENTER      = 8'd128;
   localparam logic [ACC_W-1:0] NORMAL_SERVO    = 12'd30;
   localparam logic [ACC_W-1:0] RAMP_POWER_BASE = 12'd250;
   localparam logic [ACC_W-1:0] CRUISE_POWER    = 12'd115;
   localparam logic [10:0]      TRIM_FULL       = 11'd1024;

   typedef enum logic [1:0] {
      CSR_RAMP_TARGET  = 2'd0,
      CSR_CRUISE_BASE  = 2'd1,
      CSR_BOOST_OFFSET = 2'd2,
      CSR_YAW_CAP      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic               en;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

   // Clamp a two's complement value to 0..255.
   function automatic logic [7:0] sat8(input logic [ACC_W-1:0] v);
      logic [7:0] r;
      if (v[ACC_W-1]) begin
         r = 8'd0;
      end else if (v[ACC_W-2:8] != '0) begin
         r = 8'd255;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### hdl/scm_mul.sv
// Shared registered multiplier used by the mixer sequencer.
`default_nettype none

module scm_mul (
   input  wire                            clock,
   input  scm_pkg::mul_req_type           mul_req,
   output logic [scm_pkg::MUL_P_W-1:0]    prod
);
   import scm_pkg::*;

   logic [MUL_P_W-1:0] prod_ff;

   // Hold the product unless a new operation is issued.
   always_ff @(posedge clock) begin
      if (mul_req.en) begin
         prod_ff <= MUL_P_W'(mul_req.a) * MUL_P_W'(mul_req.b);
      end
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

### hdl/stick_to_command_mixer.sv
// Top level of the stick-to-command mixer: sequencer, registers and result stage.
// Normal and cruise ticks pass through ST_STEP1 and ST_DONE, ramp ticks through
// ST_STEP1, ST_STEP2, ST_STEP3 and ST_DONE; the STEP states use the single shared
// multiplier. One item is in work at a time; ST_DONE waits for a free result slot.
// Synchronous active-high reset clears the sequencer, the result valid flag,
// the ramp counter and the last servo value, and loads the register defaults.
`default_nettype none

module stick_to_command_mixer #(
   parameter int RAMP_STEPS = 10
) (
   input  wire         clock,
   input  wire         reset,
   // input items
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [9:0]  req_yaw_sample,
   input  wire  [9:0]  req_pitch_sample,
   input  wire  [9:0]  req_throttle_sample,
   input  wire  [9:0]  req_trim_sample,
   input  wire         req_transition_switch,
   input  wire         req_boost_switch,
   input  wire         req_mode_on_switch,
   input  wire         req_mode_off_switch,
   // result items
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [7:0]  rsp_yaw_cmd,
   output logic [7:0]  rsp_servo_cmd,
   output logic [7:0]  rsp_power_cmd,
   output logic        rsp_mode_cmd,
   // register writes
   input  wire         csr_we,
   input  wire  [1:0]  csr_index,
   input  wire  [7:0]  csr_wdata
);
   import scm_pkg::*;

   // Ramp counter width follows from the step count; it saturates at RAMP_STEPS.
   localparam int             RampW    = $clog2(RAMP_STEPS + 1);
   localparam logic [RampW-1:0] RampLast = RampW'(RAMP_STEPS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP1,
      ST_STEP2,
      ST_STEP3,
      ST_DONE
   } state_type;

   // Sequencer and registers
   state_type        state_ff, state_in;
   logic [7:0]       target_ff, target_in;
   logic [7:0]       cruise_ff, cruise_in;
   logic [7:0]       boost_off_ff, boost_off_in;
   logic [7:0]       yaw_cap_ff, yaw_cap_in;
   logic [RampW-1:0] ramp_step_ff, ramp_step_in;
   logic [7:0]       last_servo_ff, last_servo_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Latched item (samples already divided by four)
   logic [7:0]       yaw_s_ff, yaw_s_in;
   logic [7:0]       pitch_s_ff, pitch_s_in;
   logic [7:0]       throttle_s_ff, throttle_s_in;
   logic [9:0]       trim_ff, trim_in;
   logic             trans_ff, trans_in;
   logic             boost_ff, boost_in;
   logic             mode_ff, mode_in;

   // Result stage
   logic [7:0]       rsp_yaw_ff, rsp_yaw_in;
   logic [7:0]       rsp_servo_ff, rsp_servo_in;
   logic [7:0]       rsp_power_ff, rsp_power_in;
   logic             rsp_mode_ff, rsp_mode_in;

   // Shared multiplier
   mul_req_type        mul_req;
   logic [MUL_P_W-1:0] prod;

   scm_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod    (prod)
   );

   // Derived terms
   logic             accept;
   logic             out_free;
   logic             ramp_active;
   logic             d_neg;
   logic [7:0]       d_mag;
   logic             diff_neg;
   logic [7:0]       diff_mag;
   logic [10:0]      trim_gap;
   logic [9:0]       q_ramp;
   logic [4:0]       q_5;
   logic [6:0]       q_12;
   logic [ACC_W-1:0] s_ext;
   logic [ACC_W-1:0] servo_raw;
   logic [ACC_W-1:0] power_raw;
   logic [7:0]       y_val;
   logic [7:0]       yaw_val;
   logic [7:0]       servo_sat;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Ramp runs while the transition is held and the counter has not reached the end.
   assign ramp_active = trans_ff && (ramp_step_ff < RampLast);

   // 128 - p equals (pitch/4) - 127; keep sign and magnitude for truncating division.
   assign d_neg = pitch_s_ff < STICK_MID;
   assign d_mag = d_neg ? (STICK_MID - pitch_s_ff) : (pitch_s_ff - STICK_MID);

   // Ramp distance from last servo to target.
   assign diff_neg = target_ff < last_servo_ff;
   assign diff_mag = diff_neg ? (last_servo_ff - target_ff) : (target_ff - last_servo_ff);

   assign trim_gap = TRIM_FULL - {1'b0, trim_ff};

   // Quotients taken from the last multiplier product.
   assign q_ramp = prod[SHIFT_100 +: 10];
   assign q_5    = prod[SHIFT_5 +: 5];
   assign q_12   = prod[SHIFT_12 +: 7];

   assign s_ext = ACC_W'(ramp_step_ff);

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_req = '0;
      unique case (state_ff)
         ST_STEP1: begin
            mul_req.en = 1'b1;
            if (ramp_active) begin
               // s * s
               mul_req.a = MUL_A_W'(ramp_step_ff);
               mul_req.b = MUL_B_W'(ramp_step_ff);
            end else if (trans_ff) begin
               // (1024 - trim) / 12
               mul_req.a = RECIP_12;
               mul_req.b = MUL_B_W'(trim_gap);
            end else begin
               // |128 - p| / 5
               mul_req.a = RECIP_5;
               mul_req.b = MUL_B_W'(d_mag);
            end
         end
         ST_STEP2: begin
            // s*s * |T - L|
            mul_req.en = 1'b1;
            mul_req.a  = MUL_A_W'(prod[7:0]);
            mul_req.b  = MUL_B_W'(diff_mag);
         end
         ST_STEP3: begin
            // divide the scaled distance by 100
            mul_req.en = 1'b1;
            mul_req.a  = RECIP_100;
            mul_req.b  = prod[MUL_B_W-1:0];
         end
         ST_IDLE, ST_DONE: begin
            mul_req = '0;
         end
         default: begin
            mul_req = '0;
         end
      endcase
   end

   // Final servo, power and yaw, evaluated in the finishing state.
   always_comb begin
      if (ramp_active) begin
         servo_raw = diff_neg ? (ACC_W'(last_servo_ff) - ACC_W'(q_ramp))
                              : (ACC_W'(last_servo_ff) + ACC_W'(q_ramp));
         power_raw = RAMP_POWER_BASE - ((s_ext << 4) - s_ext);
      end else if (trans_ff) begin
         servo_raw = ACC_W'(cruise_ff) + (boost_ff ? ACC_W'(boost_off_ff) : '0);
         power_raw = d_neg ? (CRUISE_POWER + ACC_W'(q_12) - ACC_W'(d_mag[7:2]))
                           : (CRUISE_POWER + ACC_W'(q_12) + ACC_W'(d_mag[7:2]));
      end else begin
         servo_raw = d_neg ? (NORMAL_SERVO - ACC_W'(q_5)) : (NORMAL_SERVO + ACC_W'(q_5));
         power_raw = ACC_W'(throttle_s_ff);
      end
   end

   assign servo_sat = sat8(servo_raw);

   // Dead zone returns center; otherwise clamp at the cap.
   assign y_val = ~yaw_s_ff;
   always_comb begin
      if ((y_val > DEAD_LOW) && (y_val < DEAD_HIGH)) begin
         yaw_val = YAW_CENTER;
      end else if (y_val > yaw_cap_ff) begin
         yaw_val = yaw_cap_ff;
      end else begin
         yaw_val = y_val;
      end
   end

   // Next-state logic
   always_comb begin
      state_in      = state_ff;
      target_in     = target_ff;
      cruise_in     = cruise_ff;
      boost_off_in  = boost_off_ff;
      yaw_cap_in    = yaw_cap_ff;
      ramp_step_in  = ramp_step_ff;
      last_servo_in = last_servo_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      yaw_s_in      = yaw_s_ff;
      pitch_s_in    = pitch_s_ff;
      throttle_s_in = throttle_s_ff;
      trim_in       = trim_ff;
      trans_in      = trans_ff;
      boost_in      = boost_ff;
      mode_in       = mode_ff;

      rsp_yaw_in    = rsp_yaw_ff;
      rsp_servo_in  = rsp_servo_ff;
      rsp_power_in  = rsp_power_ff;
      rsp_mode_in   = rsp_mode_ff;

      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_RAMP_TARGET:  target_in    = csr_wdata;
            CSR_CRUISE_BASE:  cruise_in    = csr_wdata;
            CSR_BOOST_OFFSET: boost_off_in = csr_wdata;
            CSR_YAW_CAP:      yaw_cap_in   = csr_wdata;
            default:          target_in    = target_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // Latch the item; the stick samples only matter divided by four.
               yaw_s_in      = req_yaw_sample[9:2];
               pitch_s_in    = req_pitch_sample[9:2];
               throttle_s_in = req_throttle_sample[9:2];
               trim_in       = req_trim_sample;
               trans_in      = req_transition_switch;
               boost_in      = req_boost_switch;
               mode_in       = req_mode_on_switch && !req_mode_off_switch;
               state_in      = ST_STEP1;
            end
         end
         ST_STEP1: begin
            state_in = ramp_active ? ST_STEP2 : ST_DONE;
         end
         ST_STEP2: begin
            state_in = ST_STEP3;
         end
         ST_STEP3: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Wait for a free result slot, then publish and advance the ramp state.
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_yaw_in    = yaw_val;
               rsp_servo_in  = servo_sat;
               rsp_power_in  = sat8(power_raw);
               rsp_mode_in   = trans_ff ? 1'b0 : mode_ff;
               last_servo_in = servo_sat;
               if (!trans_ff) begin
                  ramp_step_in = '0;
               end else if (ramp_step_ff < RampLast) begin
                  ramp_step_in = ramp_step_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         target_ff     <= RST_RAMP_TARGET;
         cruise_ff     <= RST_CRUISE_BASE;
         boost_off_ff  <= RST_BOOST_OFFSET;
         yaw_cap_ff    <= RST_YAW_CAP;
         ramp_step_ff  <= '0;
         last_servo_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         target_ff     <= target_in;
         cruise_ff     <= cruise_in;
         boost_off_ff  <= boost_off_in;
         yaw_cap_ff    <= yaw_cap_in;
         ramp_step_ff  <= ramp_step_in;
         last_servo_ff <= last_servo_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      // Payload registers carry no reset.
      yaw_s_ff      <= yaw_s_in;
      pitch_s_ff    <= pitch_s_in;
      throttle_s_ff <= throttle_s_in;
      trim_ff       <= trim_in;
      trans_ff      <= trans_in;
      boost_ff      <= boost_in;
      mode_ff       <= mode_in;
      rsp_yaw_ff    <= rsp_yaw_in;
      rsp_servo_ff  <= rsp_servo_in;
      rsp_power_ff  <= rsp_power_in;
      rsp_mode_ff   <= rsp_mode_in;
   end

   // Take a new item only when the sequencer is free.
   assign req_ready = (state_ff == ST_IDLE);

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_yaw_cmd   = rsp_yaw_ff;
   assign rsp_servo_cmd = rsp_servo_ff;
   assign rsp_power_cmd = rsp_power_ff;
   assign rsp_mode_cmd  = rsp_mode_ff;

endmodule

`default_nettype wire

### hdl/scm_checker.sv
// Port-level assertions for the stick-to-command mixer, bound to its top level.
`default_nettype none

module scm_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_ready,
   input wire        req_transition_switch,
   input wire        req_mode_on_switch,
   input wire        req_mode_off_switch,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire  [7:0] rsp_yaw_cmd,
   input wire  [7:0] rsp_servo_cmd,
   input wire  [7:0] rsp_power_cmd,
   input wire        rsp_mode_cmd
);

   // Drop any result flag on reset.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // One item at a time: no accept in the cycle after an accept.
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second item taken while busy");

   // A normal item into an empty block yields its mode in the next result, published without a stall.
   a_normal_mode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_transition_switch && !rsp_valid) |->
      ##3 (rsp_valid && (rsp_mode_cmd == $past(req_mode_on_switch && !req_mode_off_switch, 3))))
      else $error("normal item mode or latency wrong");

   // A transition item into an empty block shows no mode one where a normal result would appear.
   a_transition_mode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_transition_switch && !rsp_valid) |->
      ##3 (!rsp_valid || !rsp_mode_cmd))
      else $error("mode set during transition");

   // Hold a stalled result.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_yaw_cmd) && $stable(rsp_servo_cmd) &&
       $stable(rsp_power_cmd) && $stable(rsp_mode_cmd)))
      else $error("stalled result changed");

endmodule

bind stick_to_command_mixer scm_checker u_scm_checker (.*);

`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for the stick-to-command mixer.
`timescale 1ns / 100ps

module tb_top;
   import scm_pkg::*;

   localparam int RAMP_STEPS    = 10;
   localparam int RANDOM_ITEMS  = 760;
   localparam int SETTLE_CYCLES = 8;    // covers the ramp latency with margin
   localparam int HOLD_CYCLES   = 150;
   localparam int MAX_REPORTS   = 10;

   typedef struct packed {
      logic [9:0] yaw_sample;
      logic [9:0] pitch_sample;
      logic [9:0] throttle_sample;
      logic [9:0] trim_sample;
      logic       transition_switch;
      logic       boost_switch;
      logic       mode_on_switch;
      logic       mode_off_switch;
   } stick_item_type;

   typedef struct packed {
      logic [7:0] yaw_cmd;
      logic [7:0] servo_cmd;
      logic [7:0] power_cmd;
      logic       mode_cmd;
   } command_type;

   // Clock, reset and DUT-facing signals. Every signal driven here starts at a known value.
   logic           clock     = 1'b0;
   logic           reset     = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_ready;
   stick_item_type req_item  = '0;
   logic           rsp_valid;
   logic           rsp_ready = 1'b0;
   logic [7:0]     rsp_yaw_cmd;
   logic [7:0]     rsp_servo_cmd;
   logic [7:0]     rsp_power_cmd;
   logic           rsp_mode_cmd;
   logic           csr_we    = 1'b0;
   csr_index_type  csr_index = CSR_RAMP_TARGET;
   logic [7:0]     csr_wdata = 8'd0;

   // Pacing knobs shared by the test tasks, the sender and the result pacer.
   bit req_pace = 1'b1;
   bit rsp_pace = 1'b1;
   int rsp_hold = 0;

   // Mirror of the mixer state and its registers.
   logic [7:0] cfg_ramp_target;
   logic [7:0] cfg_cruise_base;
   logic [7:0] cfg_boost_offset;
   logic [7:0] cfg_yaw_cap;
   logic [3:0] ramp_pos;
   logic [7:0] prev_servo;

   // Commands predicted for accepted items, oldest first.
   command_type pending_cmds[$];

   int n_accepted     = 0;
   int n_checked      = 0;
   int n_mismatch     = 0;
   int n_unexpected   = 0;
   int n_reports      = 0;
   int n_ramp_ticks   = 0;
   int n_cruise_ticks = 0;
   int n_csr_writes   = 0;
   int n_input_stalls = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   stick_to_command_mixer #(
      .RAMP_STEPS(RAMP_STEPS)
   ) u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_yaw_sample       (req_item.yaw_sample),
      .req_pitch_sample     (req_item.pitch_sample),
      .req_throttle_sample  (req_item.throttle_sample),
      .req_trim_sample      (req_item.trim_sample),
      .req_transition_switch(req_item.transition_switch),
      .req_boost_switch     (req_item.boost_switch),
      .req_mode_on_switch   (req_item.mode_on_switch),
      .req_mode_off_switch  (req_item.mode_off_switch),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_yaw_cmd          (rsp_yaw_cmd),
      .rsp_servo_cmd        (rsp_servo_cmd),
      .rsp_power_cmd        (rsp_power_cmd),
      .rsp_mode_cmd         (rsp_mode_cmd),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   // Clamp a signed intermediate to the 0..255 command range.
   function automatic logic [7:0] clamp_byte(input int v);
      if (v < 0) begin
         return 8'd0;
      end
      if (v > 255) begin
         return 8'd255;
      end
      return v[7:0];
   endfunction

   // Work out the command for one tick and advance the mirrored ramp state.
   // All divisions are on signed ints, so they truncate toward zero.
   function automatic command_type mix_command(input stick_item_type it);
      int          yaw_pos;
      int          pitch_pos;
      int          servo;
      int          power;
      int          step;
      int          prior;
      command_type c;
      yaw_pos   = 255 - int'(it.yaw_sample >> 2);
      pitch_pos = 255 - int'(it.pitch_sample >> 2);
      c.mode_cmd = 1'b0;
      // Dead zone snaps yaw to center; outside it the cap applies.
      if (yaw_pos > 108 && yaw_pos < 148) begin
         c.yaw_cmd = 8'd128;
      end else if (yaw_pos > int'(cfg_yaw_cap)) begin
         c.yaw_cmd = cfg_yaw_cap;
      end else begin
         c.yaw_cmd = yaw_pos[7:0];
      end
      if (it.transition_switch) begin
         if (int'(ramp_pos) < RAMP_STEPS) begin
            // Quadratic ease from the last servo toward the target, linear power drop.
            step  = int'(ramp_pos);
            prior = int'(prev_servo);
            servo = prior + (step * step * (int'(cfg_ramp_target) - prior)) / 100;
            power = 250 - 15 * step;
            ramp_pos = ramp_pos + 4'd1;
            n_ramp_ticks++;
         end else begin
            // Counter stays saturated; cruise values with boost and trim.
            servo = int'(cfg_cruise_base) + (it.boost_switch ? int'(cfg_boost_offset) : 0);
            power = 115 + (1024 - int'(it.trim_sample)) / 12 + (128 - pitch_pos) / 4;
            n_cruise_ticks++;
         end
      end else begin
         servo      = 30 + (128 - pitch_pos) / 5;
         power      = int'(it.throttle_sample) / 4;
         c.mode_cmd = it.mode_on_switch & ~it.mode_off_switch;
         ramp_pos   = 4'd0;
      end
      prev_servo  = clamp_byte(servo);
      c.servo_cmd = prev_servo;
      c.power_cmd = clamp_byte(power);
      return c;
   endfunction

   // Scoreboard: track register writes, check each result against the oldest
   // prediction, then predict for any item accepted at this edge. Values are
   // read at the rising edge before the DUT updates them.
   always @(posedge clock) begin : scoreboard
      command_type want;
      command_type got;
      if (reset) begin
         cfg_ramp_target  = RST_RAMP_TARGET;
         cfg_cruise_base  = RST_CRUISE_BASE;
         cfg_boost_offset = RST_BOOST_OFFSET;
         cfg_yaw_cap      = RST_YAW_CAP;
         ramp_pos         = 4'd0;
         prev_servo       = 8'd0;
         pending_cmds.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_RAMP_TARGET:  cfg_ramp_target  = csr_wdata;
               CSR_CRUISE_BASE:  cfg_cruise_base  = csr_wdata;
               CSR_BOOST_OFFSET: cfg_boost_offset = csr_wdata;
               CSR_YAW_CAP:      cfg_yaw_cap      = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_yaw_cmd, rsp_servo_cmd, rsp_power_cmd, rsp_mode_cmd};
            if (pending_cmds.size() == 0) begin
               n_unexpected++;
               if (n_reports < MAX_REPORTS) begin
                  n_reports++;
                  $display("[%0t] unexpected result: yaw %0d servo %0d power %0d mode %0d",
                           $realtime, got.yaw_cmd, got.servo_cmd, got.power_cmd, got.mode_cmd);
               end
            end else begin
               want = pending_cmds.pop_front();
               n_checked++;
               if (got.yaw_cmd !== want.yaw_cmd || got.servo_cmd !== want.servo_cmd ||
                   got.power_cmd !== want.power_cmd || got.mode_cmd !== want.mode_cmd) begin
                  n_mismatch++;
                  if (n_reports < MAX_REPORTS) begin
                     n_reports++;
                     $display("[%0t] command %0d expected: yaw %0d servo %0d power %0d mode %0d",
                              $realtime, n_checked, want.yaw_cmd, want.servo_cmd,
                              want.power_cmd, want.mode_cmd);
                     $display("[%0t]   actual   yaw %0d servo %0d power %0d mode %0d",
                              $realtime, got.yaw_cmd, got.servo_cmd, got.power_cmd, got.mode_cmd);
                  end
               end
            end
         end
         if (req_valid && !req_ready) begin
            n_input_stalls++;
         end
         if (req_valid && req_ready) begin
            pending_cmds.push_back(mix_command(req_item));
            n_accepted++;
         end
      end
   end

   // Result pacer: while pacing is on, draw a random stall, possibly none, before each
   // result, or serve a long hold-off when a test asks for one; count the hold here, in cycles.
   initial begin : rsp_pacer
      int gap;
      @(negedge clock);
      while (reset) begin
         @(negedge clock);
      end
      forever begin
         gap = rsp_pace ? int'($urandom_range(19, 0)) : 0;
         if (rsp_hold > 0) begin
            gap      = rsp_hold;
            rsp_hold = 0;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   // Sensor sample that decodes to the given stick position, plus low bits.
   function automatic logic [9:0] sample_for(input int pos, input int lsb);
      return 10'((255 - pos) * 4 + lsb);
   endfunction

   function automatic stick_item_type mk_item(input logic [9:0] yaw, input logic [9:0] pitch,
                                              input logic [9:0] throttle,
                                              input logic [9:0] trim, input logic trans,
                                              input logic boost, input logic mode_on,
                                              input logic mode_off);
      stick_item_type it;
      it.yaw_sample        = yaw;
      it.pitch_sample      = pitch;
      it.throttle_sample   = throttle;
      it.trim_sample       = trim;
      it.transition_switch = trans;
      it.boost_switch      = boost;
      it.mode_on_switch    = mode_on;
      it.mode_off_switch   = mode_off;
      return it;
   endfunction

   // Fully random item; a quarter of the time aim yaw at a dead zone edge.
   function automatic stick_item_type random_item();
      stick_item_type it;
      int             y_edge;
      it.yaw_sample        = 10'($urandom_range(1023, 0));
      it.pitch_sample      = 10'($urandom_range(1023, 0));
      it.throttle_sample   = 10'($urandom_range(1023, 0));
      it.trim_sample       = 10'($urandom_range(1023, 0));
      it.transition_switch = 1'($urandom_range(1, 0));
      it.boost_switch      = 1'($urandom_range(1, 0));
      it.mode_on_switch    = 1'($urandom_range(1, 0));
      it.mode_off_switch   = 1'($urandom_range(1, 0));
      if ($urandom_range(3, 0) == 0) begin
         y_edge = 106 + int'($urandom_range(4, 0));
         if ($urandom_range(1, 0) == 1) begin
            y_edge += 39;
         end
         it.yaw_sample = sample_for(y_edge, int'($urandom_range(3, 0)));
      end
      return it;
   endfunction

   // Register value biased toward the extremes.
   function automatic logic [7:0] reg_value();
      case ($urandom_range(3, 0))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(255, 0));
      endcase
   endfunction

   // Offer one item after a random gap while pacing is on and hold it until
   // accepted. Return at the accepting edge with valid still high, so back-to-back
   // items need no drop; callers that stop sending call req_release.
   task automatic send_item(input stick_item_type it);
      int gap;
      gap = req_pace ? int'($urandom_range(19, 0)) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_item  <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic req_release();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Drop valid, wait for every predicted command to come back, then let the
   // pipeline settle.
   task automatic wait_drained();
      req_release();
      while (pending_cmds.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [7:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      n_csr_writes++;
   endtask

   // Reprogram all four registers with the block idle.
   task automatic write_settings(input logic [7:0] target, input logic [7:0] cruise,
                                 input logic [7:0] boost, input logic [7:0] cap);
      wait_drained();
      csr_write(CSR_RAMP_TARGET, target);
      csr_write(CSR_CRUISE_BASE, cruise);
      csr_write(CSR_BOOST_OFFSET, boost);
      csr_write(CSR_YAW_CAP, cap);
   endtask

   // Send a run of random items with the transition switch forced.
   task automatic send_run(input int count, input logic trans);
      stick_item_type it;
      repeat (count) begin
         it = random_item();
         it.transition_switch = trans;
         send_item(it);
      end
   endtask

   // Yaw dead zone edges and cap, stick and slider extremes, and every mode
   // switch combination, all in normal mode with the reset register values.
   task automatic test_yaw_and_mode();
      int ypos[8] = '{255, 0, 108, 109, 147, 148, 168, 169};
      int i;
      for (i = 0; i < 8; i++) begin
         send_item(mk_item(sample_for(ypos[i], (i % 2 == 1) ? 3 : 0),
                           (i % 2 == 1) ? 10'd1023 : 10'd0,
                           (i % 4 >= 2) ? 10'd1023 : 10'd0,
                           (i >= 4) ? 10'd1023 : 10'd0,
                           1'b0, 1'(i % 2), 1'(i % 2), 1'((i / 2) % 2)));
      end
   endtask

   // Full ramp into cruise with the counter held at its limit, boost and trim
   // extremes, then an early return to normal and a ramp restarted from the
   // last servo value. Mode-on stays high to show transition forces mode zero.
   task automatic test_ramp_and_cruise();
      stick_item_type it;
      int             k;
      for (k = 0; k < 13; k++) begin
         it = mk_item(10'd512, 10'd512, 10'd300, 10'd512, 1'b1, 1'b0, 1'b1, 1'b0);
         case (k)
            10: begin
               it.trim_sample  = 10'd1023;
               it.pitch_sample = 10'd1023;
            end
            11: begin
               it.boost_switch = 1'b1;
               it.trim_sample  = 10'd0;
               it.pitch_sample = 10'd0;
            end
            12: begin
               it.boost_switch = 1'b1;
               it.trim_sample  = 10'd1023;
               it.pitch_sample = 10'd0;
            end
            default: ;
         endcase
         send_item(it);
      end
      send_item(mk_item(10'd0, 10'd700, 10'd1023, 10'd0, 1'b0, 1'b0, 1'b1, 1'b0));
      send_item(mk_item(10'd1023, 10'd100, 10'd0, 10'd0, 1'b1, 1'b1, 1'b0, 1'b1));
      send_item(mk_item(10'd600, 10'd900, 10'd0, 10'd1023, 1'b1, 1'b0, 1'b0, 1'b0));
      send_item(mk_item(10'd400, 10'd200, 10'd512, 10'd0, 1'b0, 1'b0, 1'b1, 1'b1));
   endtask

   // Several register settings, extremes included: downward and upward ramps,
   // saturating cruise servo, a zero yaw cap.
   task automatic test_register_settings();
      int         ph;
      logic [7:0] t;
      logic [7:0] c;
      logic [7:0] b;
      logic [7:0] y;
      for (ph = 0; ph < 7; ph++) begin
         case (ph)
            0: begin t = 8'd0;   c = 8'd0;   b = 8'd0;   y = 8'd0;   end
            1: begin t = 8'd255; c = 8'd255; b = 8'd255; y = 8'd255; end
            2: begin t = 8'd0;   c = 8'd255; b = 8'd255; y = 8'd255; end
            3: begin t = 8'd255; c = 8'd0;   b = 8'd1;   y = 8'd0;   end
            default: begin
               t = reg_value();
               c = reg_value();
               b = reg_value();
               y = reg_value();
            end
         endcase
         write_settings(t, c, b, y);
         send_run(2, 1'b0);
         send_run(13, 1'b1);
         send_run(1, 1'b0);
      end
   endtask

   // Stop taking results for a long stretch while items keep coming, so the
   // block fills and holds off its input; then pause the sender until every
   // result is back and resume.
   task automatic test_output_stall();
      wait_drained();
      req_pace = 1'b0;
      rsp_pace = 1'b0;
      rsp_hold = HOLD_CYCLES;
      send_run(6, 1'b0);
      send_run(14, 1'b1);
      wait_drained();
      send_run(8, 1'b1);
      send_run(4, 1'b0);
      req_pace = 1'b1;
      rsp_pace = 1'b1;
   endtask

   // Mostly well-formed stretches: held transition runs, some long enough to reach
   // cruise, normal runs, and some fully random noise. Pacing changes per
   // stretch, with occasional register changes between them.
   task automatic test_random_traffic();
      int sent;
      int run;
      int kind;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         req_pace = ($urandom_range(3, 0) != 0);
         rsp_pace = ($urandom_range(3, 0) != 0);
         if ($urandom_range(11, 0) == 0) begin
            write_settings(reg_value(), reg_value(), reg_value(), reg_value());
         end
         kind = int'($urandom_range(9, 0));
         if (kind < 6) begin
            run = int'($urandom_range(16, 1));
            send_run(run, 1'b1);
         end else if (kind < 9) begin
            run = int'($urandom_range(8, 1));
            send_run(run, 1'b0);
         end else begin
            run = int'($urandom_range(8, 1));
            repeat (run) send_item(random_item());
         end
         sent += run;
      end
      req_pace = 1'b1;
      rsp_pace = 1'b1;
   endtask

   // Main sequence: reset once, run each test, drain, report.
   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_yaw_and_mode();
      test_ramp_and_cruise();
      test_register_settings();
      test_output_stall();
      test_random_traffic();

      wait_drained();
      if (pending_cmds.size() != 0) begin
         $display("%0d predicted commands never arrived", pending_cmds.size());
      end

      $display("Ran %0d items: %0d ramp ticks, %0d cruise ticks, %0d register writes.",
               n_accepted, n_ramp_ticks, n_cruise_ticks, n_csr_writes);
      $display("Checked %0d commands; input held off %0d cycles; %0d mismatches, %0d unexpected.",
               n_checked, n_input_stalls, n_mismatch, n_unexpected);
      if (n_mismatch == 0 && n_unexpected == 0 && pending_cmds.size() == 0) begin
         $display("stick_to_command_mixer verification clean");
      end else begin
         $display("stick_to_command_mixer verification failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #12_000_000;
      $display("timeout with %0d commands pending", pending_cmds.size());
      $display("stick_to_command_mixer verification failed");
      $finish;
   end

endmodule

### sim.f
hdl/scm_pkg.sv
hdl/scm_mul.sv
hdl/stick_to_command_mixer.sv
hdl/scm_checker.sv
verif/tb_top.sv
